FILE: rtl/mvp_pkg.sv
// Shared types and constants for the matrix-vector product block.
package mvp_pkg;

  localparam int ElemW = 8;
  localparam int AccW = 32;
  localparam int DimW = 5;
  localparam int RowW = 4;
  localparam logic [DimW-1:0] DimReset = 5'd4;

  localparam logic [1:0] RegDim = 2'd0;

  localparam logic [1:0] StLoad = 2'd0;
  localparam logic [1:0] StPass1 = 2'd1;
  localparam logic [1:0] StPass2 = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  // Control broadcast from the sequencer into the cell chain.
  typedef struct packed {
    logic clear;
    logic mac;
    logic load_ab;
    logic shift;
  } cell_ctrl_t;

endpackage

FILE: rtl/mvp_cell.sv
// One cell of the chain: holds one row of A, its b entry and the row sums.
module mvp_cell
  import mvp_pkg::*;
#(
  parameter int NMax = 16,
  parameter int ColW = 4
) (
  input  logic                   clk,
  input  cell_ctrl_t             ctrl,
  input  logic                   wr_en,
  input  logic [ColW-1:0]        wr_col,
  input  logic [ElemW-1:0]       wr_data,
  input  logic                   vec_wr,
  input  logic [ColW-1:0]        rd_col,
  input  logic [AccW-1:0]        operand,
  input  logic [AccW-1:0]        shift_in,
  output logic [AccW-1:0]        shift_out,
  output logic [AccW-1:0]        ab_out,
  output logic [ElemW-1:0]       vec_out
);

  logic [ElemW-1:0] row_r [NMax];
  logic [ElemW-1:0] vec_r;
  logic [AccW-1:0]  acc_r;
  logic [AccW-1:0]  ab_r;
  logic [AccW-1:0]  prod;

  assign prod = AccW'($signed({{(AccW-ElemW){row_r[rd_col][ElemW-1]}}, row_r[rd_col]})
                      * $signed(operand));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_r[wr_col] <= wr_data;
    end
    if (vec_wr) begin
      vec_r <= wr_data;
    end
    if (ctrl.clear) begin
      acc_r <= '0;
    end else if (ctrl.mac) begin
      acc_r <= acc_r + prod;
    end else if (ctrl.shift) begin
      acc_r <= shift_in;
    end
    if (ctrl.load_ab) begin
      ab_r <= acc_r;
    end else if (ctrl.shift) begin
      ab_r <= ab_r;
    end
  end

  assign shift_out = acc_r;
  assign ab_out = ab_r;
  assign vec_out = vec_r;

endmodule

FILE: rtl/matrix_vector_products.sv
// Top level: loader, sequencer and a chain of row cells for A*b, A^2*b, (A-I)*b.
//
// Usage: write dim over the APB-style cfg_ port (address 0) while idle. Then
// send dim*dim matrix entries row-major followed by dim vector entries on the
// in_ channel, one item per cycle while loading. After the last vector entry
// the block runs two passes: every cell multiplies its
// stored row by a broadcast operand (b, then A*b) and accumulates. The rows
// then leave one per result item, row 0 first, with last_row on row dim-1.
// A new load is not taken until the last row of the previous one has left;
// the passes step through the columns one at a time, set by the single
// multiplier in each cell. in_ready is low during the passes and the output.
// The output register holds while out_ready is low; nothing is lost.
// Reset (rst_n low, synchronous) sets dim to 4 and empties the load; the
// stores need no clearing since each is written before it is read.
module matrix_vector_products
  import mvp_pkg::*;
#(
  parameter int N_MAX = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [ElemW-1:0] in_elem_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [RowW-1:0]         out_row_index,
  output logic signed [AccW-1:0]  out_a_times_b,
  output logic signed [AccW-1:0]  out_a_squared_times_b,
  output logic signed [AccW-1:0]  out_a_minus_i_times_b,
  output logic                    out_last_row,
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [2:0]              cfg_paddr,
  input  logic [31:0]             cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);

  localparam int IdxW = (N_MAX > 1) ? $clog2(N_MAX) : 1;
  localparam int CntW = $clog2(N_MAX + 1);

  logic [DimW-1:0] dim_r;
  logic [1:0]      state_r;
  logic [CntW-1:0] row_r, col_r, k_r;
  logic            vphase_r;
  logic [CntW-1:0] d_eff;
  logic            cfg_wr;
  logic            in_fire;
  cell_ctrl_t      ctrl;

  logic [AccW-1:0]  acc_q [N_MAX];
  logic [AccW-1:0]  ab_q  [N_MAX];
  logic [ElemW-1:0] vec_q [N_MAX];
  logic [AccW-1:0]  shin  [N_MAX];
  logic [AccW-1:0]  operand;

  always_comb begin
    if (dim_r == '0) begin
      d_eff = CntW'(1);
    end else if (32'(dim_r) > N_MAX) begin
      d_eff = CntW'(N_MAX);
    end else begin
      d_eff = CntW'(dim_r);
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = ({1'b0, cfg_paddr[2]} == RegDim) ? 32'(dim_r) : '0;

  assign in_ready = (state_r == StLoad);
  assign in_fire = in_valid && in_ready;

  // Operand broadcast: b in the first pass, A*b (held in ab) in the second.
  assign operand = (state_r == StPass1)
    ? AccW'($signed(vec_q[k_r[IdxW-1:0]])) : ab_q[k_r[IdxW-1:0]];

  always_comb begin
    ctrl = '0;
    ctrl.mac = (state_r == StPass1 || state_r == StPass2) && (k_r < d_eff);
    ctrl.clear = (state_r == StPass1 || state_r == StPass2) && (k_r == d_eff)
                 && (state_r == StPass1);
    ctrl.load_ab = ctrl.clear;
    ctrl.shift = (state_r == StEmit) && out_valid && out_ready;
  end

  genvar g;
  generate
    for (g = 0; g < N_MAX; g++) begin : g_cell
      assign shin[g] = (g == N_MAX - 1) ? '0 : acc_q[(g + 1) % N_MAX];
      mvp_cell #(.NMax(N_MAX), .ColW(IdxW)) u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .wr_en    (in_fire && !vphase_r && row_r == CntW'(g)),
        .wr_col   (col_r[IdxW-1:0]),
        .wr_data  (in_elem_value),
        .vec_wr   (in_fire && vphase_r && col_r == CntW'(g)),
        .rd_col   (k_r[IdxW-1:0]),
        .operand  (operand),
        .shift_in (shin[g]),
        .shift_out(acc_q[g]),
        .ab_out   (ab_q[g]),
        .vec_out  (vec_q[g])
      );
    end
  endgenerate

  // Output stage walks rows by index; ab and b are read by row, A^2*b shifts up.
  logic [CntW-1:0] orow_r;
  logic [IdxW-1:0] oidx;
  assign oidx = orow_r[IdxW-1:0];
  assign out_valid = (state_r == StEmit);
  assign out_row_index = RowW'(orow_r);
  assign out_a_times_b = ab_q[oidx];
  assign out_a_squared_times_b = acc_q[0];
  assign out_a_minus_i_times_b = ab_q[oidx] - AccW'($signed(vec_q[oidx]));
  assign out_last_row = (orow_r + 1'b1 == d_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= DimReset;
      state_r <= StLoad;
      row_r <= '0;
      col_r <= '0;
      k_r <= '0;
      vphase_r <= 1'b0;
      orow_r <= '0;
    end else begin
      if (cfg_wr && {1'b0, cfg_paddr[2]} == RegDim) begin
        dim_r <= cfg_pwdata[DimW-1:0];
        row_r <= '0;
        col_r <= '0;
        vphase_r <= 1'b0;
      end else begin
        unique case (state_r)
          StLoad: begin
            if (in_fire) begin
              if (col_r + 1'b1 == d_eff) begin
                col_r <= '0;
                if (vphase_r) begin
                  vphase_r <= 1'b0;
                  row_r <= '0;
                  state_r <= StPass1;
                  k_r <= d_eff;
                end else if (row_r + 1'b1 == d_eff) begin
                  vphase_r <= 1'b1;
                end else begin
                  row_r <= row_r + 1'b1;
                end
              end else begin
                col_r <= col_r + 1'b1;
              end
            end
          end
          StPass1: begin
            // k == d clears accumulators (and latches A*b after the pass).
            if (k_r == d_eff) begin
              k_r <= '0;
              if (vphase_r) begin
                vphase_r <= 1'b0;
                state_r <= StPass2;
              end else begin
                vphase_r <= 1'b1;
              end
            end else begin
              k_r <= k_r + 1'b1;
            end
          end
          StPass2: begin
            if (k_r + 1'b1 == d_eff) begin
              state_r <= StEmit;
              orow_r <= '0;
            end
            k_r <= k_r + 1'b1;
          end
          StEmit: begin
            if (out_ready) begin
              if (out_last_row) begin
                state_r <= StLoad;
                k_r <= '0;
              end
              orow_r <= orow_r + 1'b1;
            end
          end
          default: state_r <= StLoad;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_no_in_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != StLoad) |-> !in_ready) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_row_index)))
    else $error("result dropped under stall");
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (orow_r < d_eff)) else $error("row beyond dim");
`endif

endmodule

FILE: sim/testbench.sv
// Testbench for matrix_vector_products: directed and random loads checked against a behavioral predictor.
class mvp_scoreboard;
  int unsigned dim_eff;
  int unsigned load_count;
  logic [31:0] mat [16][16];
  logic [31:0] vec [16];
  logic [3:0]  exp_row [$];
  logic [31:0] exp_ab [$];
  logic [31:0] exp_aab [$];
  logic [31:0] exp_amib [$];
  logic        exp_last [$];
  int          mismatches;

  function new();
    dim_eff = 4;
    load_count = 0;
    mismatches = 0;
  endfunction

  function void set_dim(logic [4:0] d);
    dim_eff = (d == 0) ? 1 : ((d > 16) ? 16 : d);
    load_count = 0;
  endfunction

  function void note_elem(logic signed [7:0] e);
    logic [31:0] v;
    logic [31:0] ab [16];
    logic [31:0] s;
    int unsigned nm;
    v = {{24{e[7]}}, e};
    nm = dim_eff * dim_eff;
    if (load_count < nm) begin
      mat[load_count / dim_eff][load_count % dim_eff] = v;
      load_count++;
      return;
    end
    vec[load_count - nm] = v;
    load_count++;
    if (load_count < nm + dim_eff) return;
    load_count = 0;
    for (int i = 0; i < dim_eff; i++) begin
      s = 0;
      for (int k = 0; k < dim_eff; k++) s = s + mat[i][k] * vec[k];
      ab[i] = s;
    end
    for (int i = 0; i < dim_eff; i++) begin
      s = 0;
      for (int k = 0; k < dim_eff; k++) s = s + mat[i][k] * ab[k];
      exp_row.push_back(i[3:0]);
      exp_ab.push_back(ab[i]);
      exp_aab.push_back(s);
      exp_amib.push_back(ab[i] - vec[i]);
      exp_last.push_back(i == dim_eff - 1);
    end
  endfunction

  function void fail_note(string what, logic [31:0] e, logic [31:0] a);
    mismatches++;
    if (mismatches <= 10) $display("mismatch %s: expected %h actual %h", what, e, a);
  endfunction

  function void check_row(logic [3:0] r, logic [31:0] ab, logic [31:0] aab,
                          logic [31:0] amib, logic last);
    logic [3:0] er;
    logic [31:0] eab, eaab, eamib;
    logic el;
    if (exp_row.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result item, row %0d", r);
      return;
    end
    er = exp_row.pop_front();
    eab = exp_ab.pop_front();
    eaab = exp_aab.pop_front();
    eamib = exp_amib.pop_front();
    el = exp_last.pop_front();
    if (r !== er) fail_note("row_index", er, r);
    if (ab !== eab) fail_note("a_times_b", eab, ab);
    if (aab !== eaab) fail_note("a_squared_times_b", eaab, aab);
    if (amib !== eamib) fail_note("a_minus_i_times_b", eamib, amib);
    if (last !== el) fail_note("last_row", el, last);
  endfunction

  function int pending();
    return exp_row.size();
  endfunction
endclass

module testbench;
  import mvp_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [ElemW-1:0] in_elem_value = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [RowW-1:0] out_row_index;
  logic signed [AccW-1:0] out_a_times_b, out_a_squared_times_b, out_a_minus_i_times_b;
  logic out_last_row;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [2:0] cfg_paddr = 0;
  logic [31:0] cfg_pwdata = 0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  mvp_scoreboard products = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;

  matrix_vector_products u_top (.*);

  always #1 clk = ~clk;

  // Sample results at the rising edge, decide out_ready at the falling edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      products.check_row(out_row_index, out_a_times_b, out_a_squared_times_b,
                         out_a_minus_i_times_b, out_last_row);
  end

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_dim(logic [4:0] d);
    in_valid <= 0;
    @(negedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= 3'(RegDim) << 2; cfg_pwdata <= 32'(d);
    @(negedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    products.set_dim(d);
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  // Valid stays high after an item; the caller drops it once the sender stops.
  task automatic send_elem(logic signed [7:0] e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_elem_value <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    products.note_elem(e);
    @(negedge clk);
  endtask

  function automatic logic signed [7:0] rand_elem();
    case ($urandom_range(5))
      0: return -8'sd128;
      1: return 8'sd127;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_load(int d);
    for (int i = 0; i < d * d + d; i++) send_elem(rand_elem());
  endtask

  task automatic drain();
    in_valid <= 0;
    while (products.pending() > 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  initial begin
    int sent;
    int d;
    repeat (3) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // Directed: reset dim with extreme values, then dim 1 and zero dim.
    for (int i = 0; i < 20; i++) send_elem((i % 2) ? -8'sd128 : 8'sd127);
    drain();
    write_dim(5'd1);
    send_elem(-8'sd128); send_elem(-8'sd128);
    send_elem(8'sd127); send_elem(8'sd1);
    drain();
    write_dim(5'd0);
    send_elem(8'sd0); send_elem(8'sd127);
    drain();
    // A write in mid-load discards the partial load.
    write_dim(5'd2);
    send_elem(8'sd5); send_elem(8'sd9);
    in_valid <= 0;
    repeat (5) @(negedge clk);
    write_dim(5'd31);
    send_load(16);
    drain();
    write_dim(5'd4);
    // Long receiver stall while the sender keeps offering items.
    hold_off = 100;
    send_load(4);
    send_load(4);
    send_load(4);
    drain();
    sent = 0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 7 : ((ph == 1) ? 80 : 0);
      recv_idle_pct = (ph == 0) ? 80 : ((ph == 1) ? 7 : 0);
      while (sent < 50 * (ph + 1)) begin
        d = ($urandom_range(9) == 0) ? $urandom_range(8, 1) : $urandom_range(4, 1);
        write_dim(d[4:0]);
        d = (d > 16) ? 16 : d;
        send_load(d);
        sent += d * d + d;
        drain();
      end
    end
    recv_idle_pct = 0;
    drain();
    if (products.mismatches == 0 && products.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/mvp_pkg.sv
rtl/mvp_cell.sv
rtl/matrix_vector_products.sv
sim/testbench.sv
